// ----- rtl/core/ghc_pkg.sv -----
// Package for the gear hash chunk cutter.
// Holds register codes, cut reason codes, reset values, the config struct
// and the built-in gear table. No dependencies.
`default_nettype none

package ghc_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int HASH_BITS_DEFAULT   = 32;
  localparam int GEAR_IDX_W          = 6;
  localparam int BUILTIN_WORDS       = 54;
  localparam int CFG_IDX_W           = 3;

  localparam logic OP_DATA        = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SIZE    = 3'd0,
    REG_NORMAL_SIZE = 3'd1,
    REG_MAX_SIZE    = 3'd2,
    REG_MASK_SMALL  = 3'd3,
    REG_MASK_LARGE  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CUT_SMALL_MASK = 2'd0,
    CUT_LARGE_MASK = 2'd1,
    CUT_MAX_SIZE   = 2'd2,
    CUT_END_STREAM = 2'd3
  } cut_reason_e;

  localparam logic [15:0] MIN_SIZE_RESET    = 16'd4096;
  localparam logic [15:0] NORMAL_SIZE_RESET = 16'd4096;
  localparam logic [15:0] MAX_SIZE_RESET    = 16'd16384;
  localparam logic [31:0] MASK_SMALL_RESET  = 32'd16383;
  localparam logic [31:0] MASK_LARGE_RESET  = 32'd4095;

  typedef struct packed {
    logic [15:0] min_size;
    logic [15:0] normal_size;
    logic [15:0] max_size;
    logic [31:0] mask_small;
    logic [31:0] mask_large;
  } cutter_cfg_t;

  function automatic logic [31:0] gear_rom(input logic [GEAR_IDX_W-1:0] idx);
    logic [31:0] w;
    case (idx)
      6'd0:  w = 32'h5C95C078;
      6'd1:  w = 32'h22408989;
      6'd2:  w = 32'h2D48A214;
      6'd3:  w = 32'h12842087;
      6'd4:  w = 32'h530F8AFB;
      6'd5:  w = 32'h474536B9;
      6'd6:  w = 32'h2963B4F1;
      6'd7:  w = 32'h44CB738B;
      6'd8:  w = 32'h4EA7403D;
      6'd9:  w = 32'h4D606B6E;
      6'd10: w = 32'h074EC5D3;
      6'd11: w = 32'h3AF39D18;
      6'd12: w = 32'h726003CA;
      6'd13: w = 32'h37A62A74;
      6'd14: w = 32'h51A2F58E;
      6'd15: w = 32'h7506358E;
      6'd16: w = 32'h5D4AB128;
      6'd17: w = 32'h4D4AE17B;
      6'd18: w = 32'h41E85924;
      6'd19: w = 32'h470C36F7;
      6'd20: w = 32'h4741CBE1;
      6'd21: w = 32'h01BB7F30;
      6'd22: w = 32'h617C1DE3;
      6'd23: w = 32'h2B0C3A1F;
      6'd24: w = 32'h50C48F73;
      6'd25: w = 32'h21A82D37;
      6'd26: w = 32'h6095ACE0;
      6'd27: w = 32'h419167A0;
      6'd28: w = 32'h3CAF49B0;
      6'd29: w = 32'h40CEA62D;
      6'd30: w = 32'h66BC1C66;
      6'd31: w = 32'h545E1DAD;
      6'd32: w = 32'h2BFA77CD;
      6'd33: w = 32'h6E85DA24;
      6'd34: w = 32'h5FB0BDC5;
      6'd35: w = 32'h652CFC29;
      6'd36: w = 32'h3A0AE1AB;
      6'd37: w = 32'h2837E0F3;
      6'd38: w = 32'h6387B70E;
      6'd39: w = 32'h13176012;
      6'd40: w = 32'h4362C2BB;
      6'd41: w = 32'h66D8F4B1;
      6'd42: w = 32'h37FCE834;
      6'd43: w = 32'h2C9CD386;
      6'd44: w = 32'h21144296;
      6'd45: w = 32'h627268A8;
      6'd46: w = 32'h650DF537;
      6'd47: w = 32'h2805D579;
      6'd48: w = 32'h3B21EBBD;
      6'd49: w = 32'h7357ED34;
      6'd50: w = 32'h3F58B583;
      6'd51: w = 32'h7150DDCA;
      6'd52: w = 32'h7362225E;
      6'd53: w = 32'h620A6070;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ghc_gear_table.sv -----
// Writable gear table: memory with one valid bit per entry over the
// built-in words, registered read. Depends on ghc_pkg.
`default_nettype none

module ghc_gear_table
  import ghc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [GEAR_IDX_W-1:0] wr_index,
  input  wire logic [31:0]           wr_word,
  input  wire logic                  rd_en,
  input  wire logic [GEAR_IDX_W-1:0] rd_index,
  output logic      [31:0]           gear
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [31:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written;
  logic                   wr_in_range;
  logic                   rd_in_range;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [31:0]            rd_data;
  logic [31:0]            rd_rom;
  logic                   rd_written;
  logic                   rd_range;

  assign wr_in_range = ({26'd0, wr_index} < 32'(TABLE_DEPTH));
  assign rd_in_range = ({26'd0, rd_index} < 32'(TABLE_DEPTH));
  assign wr_addr     = ADDR_W'(wr_index);
  assign rd_addr     = ADDR_W'(rd_index);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en && wr_in_range) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_written <= written[rd_addr];
      rd_rom     <= gear_rom(rd_index);
      rd_range   <= rd_in_range;
    end
  end

  always_comb begin
    if (!rd_range) begin
      gear = 32'd0;
    end else if (rd_written) begin
      gear = rd_data;
    end else begin
      gear = rd_rom;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ghc_cut_stage.sv -----
// Fingerprint update, cut decision and result register.
// Depends on ghc_pkg.
`default_nettype none

module ghc_cut_stage
  import ghc_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cutter_cfg_t cfg,
  input  wire logic        go,
  input  wire logic        last,
  input  wire logic [31:0] gear,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [15:0]      chunk_length,
  output logic [1:0]       cut_reason
);

  logic [HASH_BITS-1:0] fingerprint;
  logic [HASH_BITS-1:0] fingerprint_next;
  logic [HASH_BITS-1:0] fp_hashed;
  logic [15:0]          position;
  logic [15:0]          position_next;
  logic [16:0]          len;
  logic                 hashed;
  logic                 small_zone;
  logic [31:0]          mask;
  logic                 mask_hit;
  logic                 max_hit;
  logic                 cut;
  cut_reason_e          reason;

  always_comb begin
    len        = {1'b0, position} + 17'd1;
    hashed     = (position >= cfg.min_size);
    small_zone = (position < cfg.normal_size);
    mask       = small_zone ? cfg.mask_small : cfg.mask_large;
    fp_hashed  = (fingerprint >> 1) + HASH_BITS'(gear);
    mask_hit   = hashed && ((64'(fp_hashed) & 64'(mask)) == 64'd0);
    max_hit    = (len >= {1'b0, cfg.max_size});
    cut        = mask_hit || max_hit || last;
    if (mask_hit) begin
      reason = small_zone ? CUT_SMALL_MASK : CUT_LARGE_MASK;
    end else if (max_hit) begin
      reason = CUT_MAX_SIZE;
    end else begin
      reason = CUT_END_STREAM;
    end
    if (cut) begin
      fingerprint_next = '0;
      position_next    = 16'd0;
    end else begin
      fingerprint_next = hashed ? fp_hashed : fingerprint;
      position_next    = len[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fingerprint <= '0;
      position    <= 16'd0;
    end else if (go) begin
      fingerprint <= fingerprint_next;
      position    <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && cut) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && cut) begin
      chunk_length <= len[15:0];
      cut_reason   <= reason;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gear_hash_chunk_cutter.sv -----
// Gear hash chunk cutter, top level: config registers, input stage,
// gear table and cut stage. Depends on ghc_pkg, ghc_gear_table, ghc_cut_stage.
//
// Takes one beat per clock: a data byte, or a write of one gear table entry
// (no result). A byte's table entry is read into the input stage register at
// acceptance, and the fingerprint update and cut test run when that byte
// leaves the input stage, which a waiting result can hold back; the chunk
// result is then registered in the output register. Input is stalled only while
// a byte sits in the input stage and a result waits unaccepted in the output
// register. Config writes take effect at once and are meant for idle periods.
`default_nettype none

module gear_hash_chunk_cutter
  import ghc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int HASH_BITS   = HASH_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  operation,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_in_stream,
  input  wire logic [GEAR_IDX_W-1:0] table_index,
  input  wire logic [31:0]           table_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                chunk_length,
  output logic [1:0]                 cut_reason
);

  cutter_cfg_t cfg;
  logic        s1_valid;
  logic        s1_last;
  logic        go;
  logic        in_beat;
  logic        data_beat;
  logic        table_beat;
  logic [31:0] gear;

  assign cfg_ready  = 1'b1;
  assign go         = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || go;
  assign in_beat    = in_valid && in_ready;
  assign data_beat  = in_beat && (operation == OP_DATA);
  assign table_beat = in_beat && (operation == OP_TABLE_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_size    <= MIN_SIZE_RESET;
      cfg.normal_size <= NORMAL_SIZE_RESET;
      cfg.max_size    <= MAX_SIZE_RESET;
      cfg.mask_small  <= MASK_SMALL_RESET;
      cfg.mask_large  <= MASK_LARGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_SIZE:    cfg.min_size    <= cfg_data[15:0];
        REG_NORMAL_SIZE: cfg.normal_size <= cfg_data[15:0];
        REG_MAX_SIZE:    cfg.max_size    <= cfg_data[15:0];
        REG_MASK_SMALL:  cfg.mask_small  <= cfg_data;
        REG_MASK_LARGE:  cfg.mask_large  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_beat) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_beat) begin
      s1_last <= last_in_stream;
    end
  end

  ghc_gear_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (table_beat),
    .wr_index(table_index),
    .wr_word (table_word),
    .rd_en   (data_beat),
    .rd_index(data_byte[GEAR_IDX_W-1:0]),
    .gear    (gear)
  );

  ghc_cut_stage #(
    .HASH_BITS(HASH_BITS)
  ) u_cut (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .go          (go),
    .last        (s1_last),
    .gear        (gear),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .chunk_length(chunk_length),
    .cut_reason  (cut_reason)
  );

`ifndef SYNTHESIS
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chunk_length != 16'd0)
    else $error("chunk length zero");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while stage blocked");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input refused with empty stage");

  a_max_cut_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cut_reason == CUT_MAX_SIZE && cfg.max_size != 16'd0)
      |-> chunk_length >= cfg.max_size)
    else $error("max size cut below max size");
`endif

endmodule

`default_nettype wire
